[src/dynamic_palette_pixel_packer_defines.svh]
// Assertion macros for the checker file of the palette packer.
`ifndef DYNAMIC_PALETTE_PIXEL_PACKER_DEFINES_SVH
`define DYNAMIC_PALETTE_PIXEL_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpp checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is low.
`define DPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpp checker: next-cycle property failed");

`endif

[src/dpp_pkg.sv]
`default_nettype none

package dpp_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W         = IDX_W + 1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [7:0]       t_byte;
    typedef logic [1:0]       t_code;

    // Pixel depth codes.
    localparam t_code CODE_BPP1 = 2'd0;
    localparam t_code CODE_BPP2 = 2'd1;
    localparam t_code CODE_BPP4 = 2'd2;
    localparam t_code CODE_BPP8 = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_HOLD
    } t_state;

    // Search token that walks down the palette cells.
    typedef struct packed {
        logic  valid;
        t_byte color;
        t_cnt  searched;
        logic  can_add;
        logic  found;
        logic  added;
        t_idx  idx;
    } t_tok;

    // Request to the byte packer.
    typedef struct packed {
        logic  load;
        t_code code;
        logic  fs;
        t_byte col;
        logic  rend;
        t_byte idx;
    } t_pack_in;

    typedef struct packed {
        logic  byte_valid;
        t_byte packed_byte;
        t_byte byte_column;
    } t_pack_out;

    // Number of usable palette entries for a depth code.
    function automatic t_cnt dpp_limit(input t_code code);
        int lim;
        lim = 256;
        unique case (code)
            CODE_BPP1: lim = 2;
            CODE_BPP2: lim = 4;
            CODE_BPP4: lim = 16;
            CODE_BPP8: lim = 256;
            default:   lim = 256;
        endcase
        if (lim > PALETTE_DEPTH) begin
            lim = PALETTE_DEPTH;
        end
        return t_cnt'(lim);
    endfunction

    // Index mask for a depth code.
    function automatic t_byte dpp_mask(input t_code code);
        t_byte m;
        m = 8'hFF;
        unique case (code)
            CODE_BPP1: m = 8'h01;
            CODE_BPP2: m = 8'h03;
            CODE_BPP4: m = 8'h0F;
            CODE_BPP8: m = 8'hFF;
            default:   m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[src/dpp_intf.sv]
`default_nettype none

interface dpp_pix_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] column;
    logic [7:0] pixel_color;
    logic       row_end;

    modport source (output valid, frame_start, column, pixel_color, row_end, input ready);
    modport sink   (input valid, frame_start, column, pixel_color, row_end, output ready);
endinterface

interface dpp_res_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] packed_byte;
    logic [7:0] byte_column;
    logic       row_done;
    logic [7:0] color_index;
    logic       color_added;
    logic       palette_overflow;

    modport source (output valid, byte_valid, packed_byte, byte_column, row_done,
                    color_index, color_added, palette_overflow, input ready);
    modport sink   (input valid, byte_valid, packed_byte, byte_column, row_done,
                    color_index, color_added, palette_overflow, output ready);
endinterface

interface dpp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] pixel_depth_code;

    modport source (output valid, pixel_depth_code, input ready);
    modport sink   (input valid, pixel_depth_code, output ready);
endinterface

`default_nettype wire

[src/dpp_cell.sv]
`default_nettype none

module dpp_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dpp_pkg::t_idx i_cell_idx,
    input  dpp_pkg::t_tok i_tok,
    output dpp_pkg::t_tok o_tok
);
    import dpp_pkg::*;

    t_byte r_entry;
    t_tok  r_tok;
    t_tok  n_tok;
    t_cnt  w_pos;
    logic  w_live;
    logic  w_hit;
    logic  w_add;

    // The entry is live only below the searched count; the first free one takes a new color.
    always_comb begin
        w_pos  = {1'b0, i_cell_idx};
        w_live = i_tok.valid && !i_tok.found;
        w_hit  = w_live && (w_pos < i_tok.searched) && (r_entry == i_tok.color);
        w_add  = w_live && i_tok.can_add && (w_pos == i_tok.searched);
        n_tok  = i_tok;
        if (w_hit || w_add) begin
            n_tok.found = 1'b1;
            n_tok.idx   = i_cell_idx;
        end
        n_tok.added = i_tok.added || w_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_add) begin
            r_entry <= i_tok.color;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

[src/dpp_packer.sv]
`default_nettype none

module dpp_packer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dpp_pkg::t_pack_in  i_req,
    output dpp_pkg::t_pack_out o_res
);
    import dpp_pkg::*;

    t_byte      r_pending;
    t_byte      n_pending;
    logic [2:0] w_slot;
    logic [3:0] w_bpp;
    logic [3:0] w_shift;
    t_byte      w_base;
    t_byte      w_shifted;
    t_byte      w_byte;
    logic       w_full;

    always_comb begin
        w_slot    = i_req.col[2:0] & (3'd7 >> i_req.code);
        w_bpp     = 4'd1 << i_req.code;
        w_shift   = 4'd8 - w_bpp - (4'(w_slot) << i_req.code);
        w_base    = (i_req.fs || (w_slot == 3'd0)) ? 8'h00 : r_pending;
        w_shifted = i_req.idx << w_shift;
        w_byte    = w_base | w_shifted;
        w_full    = (w_shift == 4'd0) || i_req.rend;
        n_pending = r_pending;
        if (i_req.load) begin
            n_pending = w_full ? 8'h00 : w_byte;
        end
        o_res.byte_valid  = w_full;
        o_res.packed_byte = w_full ? w_byte : 8'h00;
        o_res.byte_column = i_req.col >> (2'd3 - i_req.code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 8'h00;
        end else begin
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

[src/dynamic_palette_pixel_packer.sv]
// An accepted pixel beat passes the chain of palette cells, the hold register and the
// output register before its result beat comes out; the search token must walk the
// whole chain of palette cells, one cell per cycle, before the next pixel is taken.
// Reset (synchronous, active low) empties the chain, clears the palette count and the
// pending byte, and sets the depth code to 8 bits per pixel; palette entries keep garbage.
`default_nettype none

module dynamic_palette_pixel_packer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dpp_pix_if.sink          i_pix,
    dpp_res_if.source        o_res,
    dpp_cfg_if.sink          i_cfg
);
    import dpp_pkg::*;

    // Control state.
    t_state r_state;
    t_state n_state;
    logic   w_in_ready;
    logic   w_in_acc;
    logic   w_exit;
    logic   w_out_free;
    logic   w_res_load;

    // Configuration and palette bookkeeping.
    t_code  r_code;
    t_cnt   r_count;
    t_cnt   n_count;
    t_cnt   w_eff_count;
    t_cnt   w_limit;

    // The pixel under search and the token that came out of the chain.
    logic   r_fs;
    logic   r_rend;
    t_byte  r_col;
    t_tok   r_hold;
    t_tok   w_head;
    t_tok   w_chain [PALETTE_DEPTH+1];

    t_pack_in  w_pack_in;
    t_pack_out w_pack_out;

    // Output register.
    logic  r_out_valid;
    logic  r_byte_valid;
    t_byte r_packed_byte;
    t_byte r_byte_column;
    logic  r_row_done;
    t_byte r_color_index;
    logic  r_color_added;
    logic  r_overflow;

    // Config is always ready; the user must write it only while idle, unenforced here.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= CODE_BPP8;
        end else if (i_cfg.valid) begin
            r_code <= i_cfg.pixel_depth_code;
        end
    end

    // Handshake glue. The output register frees the search from the sink: a new pixel
    // may start while the previous result still waits to be taken.
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_in_acc   = i_pix.valid && w_in_ready;
    assign w_exit     = w_chain[PALETTE_DEPTH].valid;
    assign i_pix.ready = w_in_ready;

    // Next state: idle until a pixel arrives, search while the token walks the cells,
    // then hold the finished token until the output register has room.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_exit) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        w_in_ready = 1'b0;
        w_res_load = 1'b0;
        unique case (r_state)
            S_IDLE:   w_in_ready = 1'b1;
            S_SEARCH: w_in_ready = 1'b0;
            S_HOLD:   w_res_load = w_out_free;
            default: begin
                w_in_ready = 1'b0;
                w_res_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A frame start empties the palette before its own pixel is looked up. Only entries
    // below the smaller of the count and the depth limit take part in the match, and a
    // new color may be appended only while the count is below the limit.
    always_comb begin
        w_limit         = dpp_limit(r_code);
        w_eff_count     = i_pix.frame_start ? '0 : r_count;
        w_head.valid    = w_in_acc;
        w_head.color    = i_pix.pixel_color;
        w_head.searched = (w_eff_count < w_limit) ? w_eff_count : w_limit;
        w_head.can_add  = (w_eff_count < w_limit);
        w_head.found    = 1'b0;
        w_head.added    = 1'b0;
        w_head.idx      = '0;
    end

    assign w_chain[0] = w_head;

    // The palette itself: one cell per entry. Each cell compares its color with the
    // passing token, stores the color if it is the first free entry, and passes the
    // token on to the next cell in the following cycle.
    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        dpp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (t_idx'(g)),
            .i_tok      (w_chain[g]),
            .o_tok      (w_chain[g+1])
        );
    end

    // The count is settled at accept time for a frame start and grows when the result
    // is retired with a new entry; the token cannot append past the limit.
    always_comb begin
        n_count = r_count;
        if (w_in_acc) begin
            n_count = w_eff_count;
        end else if (w_res_load && r_hold.added) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Pixel fields that the packer needs once the search is done.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_fs   <= i_pix.frame_start;
            r_col  <= i_pix.column;
            r_rend <= i_pix.row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exit) begin
            r_hold <= w_chain[PALETTE_DEPTH];
        end
    end

    // Packing of the index into the pending byte, MSB first.
    always_comb begin
        w_pack_in.load = w_res_load;
        w_pack_in.code = r_code;
        w_pack_in.fs   = r_fs;
        w_pack_in.col  = r_col;
        w_pack_in.rend = r_rend;
        w_pack_in.idx  = t_byte'(r_hold.idx) & dpp_mask(r_code);
    end

    dpp_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_pack_in),
        .o_res   (w_pack_out)
    );

    // Result register. A color that was neither found nor appended overflowed and
    // takes index 0, which the token carries from its start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_byte_valid  <= w_pack_out.byte_valid;
            r_packed_byte <= w_pack_out.packed_byte;
            r_byte_column <= w_pack_out.byte_column;
            r_row_done    <= r_rend;
            r_color_index <= w_pack_in.idx;
            r_color_added <= r_hold.added;
            r_overflow    <= !r_hold.found;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.byte_valid       = r_byte_valid;
    assign o_res.packed_byte      = r_packed_byte;
    assign o_res.byte_column      = r_byte_column;
    assign o_res.row_done         = r_row_done;
    assign o_res.color_index      = r_color_index;
    assign o_res.color_added      = r_color_added;
    assign o_res.palette_overflow = r_overflow;

endmodule

`default_nettype wire

[src/dpp_checker.sv]
`default_nettype none
`include "dynamic_palette_pixel_packer_defines.svh"

module dpp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_byte_valid,
    input logic [7:0] i_packed_byte,
    input logic       i_row_done,
    input logic       i_color_added,
    input logic       i_palette_overflow
);

    // A stalled result beat keeps its byte.
    `DPP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_packed_byte))

    // One pixel is searched at a time.
    `DPP_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A color is either appended or overflowed, never both.
    `DPP_ASSERT_IMP(a_add_xor_ovf, i_clk, i_rst_n, i_out_valid, !(i_color_added && i_palette_overflow))

    // The end of a row always flushes the pending byte.
    `DPP_ASSERT_IMP(a_row_flush, i_clk, i_rst_n, i_out_valid && i_row_done, i_byte_valid)

    // Without a byte the byte field reads zero.
    `DPP_ASSERT_IMP(a_empty_byte, i_clk, i_rst_n, i_out_valid && !i_byte_valid, i_packed_byte == 8'h00)

endmodule

bind dynamic_palette_pixel_packer dpp_checker u_dpp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_pix.valid),
    .i_in_ready         (i_pix.ready),
    .i_out_valid        (o_res.valid),
    .i_out_ready        (o_res.ready),
    .i_byte_valid       (o_res.byte_valid),
    .i_packed_byte      (o_res.packed_byte),
    .i_row_done         (o_res.row_done),
    .i_color_added      (o_res.color_added),
    .i_palette_overflow (o_res.palette_overflow)
);

`default_nettype wire

[tb/dynamic_palette_pixel_packer_checker.sv]
module dynamic_palette_pixel_packer_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dpp_pix_if   pix,
    dpp_res_if   res,
    dpp_cfg_if   cfg,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dpp_pkg::*;

    typedef struct packed {
        logic  byte_valid;
        t_byte packed_byte;
        t_byte byte_column;
        logic  row_done;
        t_byte color_index;
        logic  color_added;
        logic  palette_overflow;
    } t_result;

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the palette, the partially packed byte and the depth register.
    t_byte   palette_mem [PALETTE_DEPTH];
    t_cnt    palette_used;
    t_byte   partial_byte;
    t_code   depth_code;
    t_result awaited_results [$];
    int      fail_count = 0;

    // Looks the color up, grows the palette and packs the index into the running byte.
    function automatic t_result predict_pack(input logic fs, input t_byte col,
                                             input t_byte color, input logic rend);
        int unsigned bits;
        int unsigned per_byte;
        int unsigned entries;
        int unsigned slot;
        int unsigned shift;
        int unsigned i;
        t_byte       idx_mask;
        t_byte       idx;
        t_byte       merged;
        logic        hit;
        t_result     r;
        bits     = 1 << depth_code;
        per_byte = 8 / bits;
        entries  = 1 << bits;
        idx_mask = t_byte'(entries - 1);
        if (entries > PALETTE_DEPTH) begin
            entries = PALETTE_DEPTH;
        end
        if (fs) begin
            palette_used = '0;
            partial_byte = '0;
        end
        r   = '0;
        hit = 1'b0;
        idx = '0;
        for (i = 0; i < entries && i < palette_used; i++) begin
            if (!hit && palette_mem[i] == color) begin
                hit = 1'b1;
                idx = t_byte'(i);
            end
        end
        if (!hit) begin
            if (palette_used < entries) begin
                idx = t_byte'(palette_used);
                palette_mem[palette_used] = color;
                palette_used = palette_used + 1'b1;
                r.color_added = 1'b1;
            end else begin
                r.palette_overflow = 1'b1;
            end
        end
        idx    = idx & idx_mask;
        slot   = col % per_byte;
        shift  = 8 - bits - slot * bits;
        merged = ((slot == 0) ? 8'h00 : partial_byte) | t_byte'(idx << shift);
        r.byte_valid  = (shift == 0) || rend;
        r.packed_byte = r.byte_valid ? merged : 8'h00;
        r.byte_column = t_byte'(col / per_byte);
        r.row_done    = rend;
        r.color_index = idx;
        partial_byte  = r.byte_valid ? 8'h00 : merged;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            awaited_results.delete();
            palette_used = '0;
            partial_byte = '0;
            depth_code   = CODE_BPP8;
        end else begin
            if (cfg.valid && cfg.ready) begin
                depth_code = cfg.pixel_depth_code;
            end
            if (pix.valid && pix.ready) begin
                awaited_results.push_back(predict_pack(pix.frame_start, pix.column,
                                                       pix.pixel_color, pix.row_end));
            end
            if (res.valid && res.ready) begin
                got = '{res.byte_valid, res.packed_byte, res.byte_column, res.row_done,
                        res.color_index, res.color_added, res.palette_overflow};
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("ERROR: result beat with no pixel outstanding: %p", got);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("ERROR: expected valid=%0b byte=%02h bcol=%0d done=%0b",
                                     want.byte_valid, want.packed_byte, want.byte_column,
                                     want.row_done, " idx=%0d add=%0b ovf=%0b",
                                     want.color_index, want.color_added,
                                     want.palette_overflow);
                            $display("       got      valid=%0b byte=%02h bcol=%0d done=%0b",
                                     got.byte_valid, got.packed_byte, got.byte_column,
                                     got.row_done, " idx=%0d add=%0b ovf=%0b",
                                     got.color_index, got.color_added, got.palette_overflow);
                        end
                    end
                end
            end
        end
        o_errors  <= fail_count;
        o_pending <= awaited_results.size();
    end

endmodule

[tb/dynamic_palette_pixel_packer_tb.sv]
module dynamic_palette_pixel_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dpp_pkg::*;

    // One pixel beat as the sender builds it.
    typedef struct packed {
        logic  fs;
        t_byte col;
        t_byte color;
        logic  rend;
    } t_pixel_beat;

    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 135;
    // The receiver goes deaf for this many cycles at the start of this phase.
    localparam int PRESSURE_PHASE  = 6;
    localparam int HOLD_CYCLES     = 1200;
    // Quiet time at the end of the run, for any stray result beat to show up.
    localparam int TAIL_CYCLES     = 300;
    // Longest quiet stretch of a correct run is the receiver hold plus one
    // pixel's latency; the limit sits several times above that.
    localparam int WATCHDOG_LIMIT  = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dpp_pix_if pix_if ();
    dpp_res_if res_if ();
    dpp_cfg_if cfg_if ();

    int chk_errors;
    int chk_pending;

    // Idle percentages and the current phase, shared by the sender and receiver.
    int tx_idle_pct;
    int rx_idle_pct;
    int phase_num = -1;

    // State of the well-formed frame generator: frames of a few rows, each row
    // walking its columns from zero, colors drawn mostly from a small pool so
    // that palette hits and overflows both happen.
    int    rows_left = 0;
    int    walk_col;
    int    walk_last;
    logic  frame_head;
    t_byte color_pool [32];
    int    pool_len;

    int quiet_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    dynamic_palette_pixel_packer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    dynamic_palette_pixel_packer_checker checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .pix       (pix_if),
        .res       (res_if),
        .cfg       (cfg_if),
        .o_errors  (chk_errors),
        .o_pending (chk_pending)
    );

    function automatic t_pixel_beat px(input logic fs, input int col, input int color,
                                       input logic rend);
        t_pixel_beat p;
        p.fs    = fs;
        p.col   = t_byte'(col);
        p.color = t_byte'(color);
        p.rend  = rend;
        return p;
    endfunction

    // Most rows are short; now and then a full 256-column row reaches the top column.
    function automatic int pick_row_last();
        return ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 23);
    endfunction

    // Produces the next random pixel: mostly well-formed frames, the rest noise
    // with stray columns, frame starts and row ends.
    function automatic t_pixel_beat next_pixel();
        t_pixel_beat p;
        int          i;
        if ($urandom_range(0, 99) < 15) begin
            p.fs    = ($urandom_range(0, 7) == 0);
            p.col   = t_byte'($urandom);
            p.color = t_byte'($urandom);
            p.rend  = ($urandom_range(0, 3) == 0);
            return p;
        end
        if (rows_left == 0) begin
            rows_left  = $urandom_range(1, 4);
            pool_len   = $urandom_range(1, 24);
            for (i = 0; i < pool_len; i++) begin
                color_pool[i] = t_byte'($urandom);
            end
            frame_head = 1'b1;
            walk_col   = 0;
            walk_last  = pick_row_last();
        end
        p.fs       = frame_head;
        frame_head = 1'b0;
        p.col      = t_byte'(walk_col);
        p.color    = ($urandom_range(0, 4) == 0) ? t_byte'($urandom)
                                                 : color_pool[$urandom_range(0, pool_len - 1)];
        p.rend     = (walk_col == walk_last);
        if (p.rend) begin
            rows_left--;
            walk_col  = 0;
            walk_last = pick_row_last();
        end else begin
            walk_col++;
        end
        return p;
    endfunction

    // Called at a falling edge. Offers one pixel beat, possibly after some idle
    // cycles, and returns at the falling edge after the beat was taken. Valid
    // stays high into the next call, so back-to-back beats never drop it.
    task automatic push_pixel(input t_pixel_beat p);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.frame_start <= p.fs;
        pix_if.column      <= p.col;
        pix_if.pixel_color <= p.color;
        pix_if.row_end     <= p.rend;
        do @(posedge i_clk); while (!pix_if.ready);
        @(negedge i_clk);
    endtask

    // Stops offering pixels and waits until every result of the phase is back.
    // Each pixel gives exactly one result, so an empty scoreboard means idle.
    task automatic drain_results();
        pix_if.valid <= 1'b0;
        while (chk_pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Writes the depth register while the packer is idle.
    task automatic write_depth(input t_code code);
        cfg_if.valid            <= 1'b1;
        cfg_if.pixel_depth_code <= code;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Receiver: random back-pressure, plus one long hold at the pressure phase
    // while the sender keeps pixels on offer, so the packer fills and stalls.
    initial begin : receiver
        int   hold_left;
        logic hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && phase_num == PRESSURE_PHASE) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int          ph;
        int          n;
        int          j;
        int          tmp;
        int          sweep_colors [256];
        t_code       phase_codes [RANDOM_PHASES];
        t_code       code;
        t_pixel_beat p;

        phase_codes = '{CODE_BPP1, CODE_BPP8, CODE_BPP2, CODE_BPP4,
                        CODE_BPP1, CODE_BPP8, CODE_BPP2, CODE_BPP4};

        // Every input is known from time zero.
        i_rst_n                 = 1'b0;
        pix_if.valid            = 1'b0;
        pix_if.frame_start      = 1'b0;
        pix_if.column           = '0;
        pix_if.pixel_color      = '0;
        pix_if.row_end          = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.pixel_depth_code = CODE_BPP8;
        tx_idle_pct             = 11;
        rx_idle_pct             = 52;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. First at the reset depth of 8 bits per pixel: the
        // extreme columns and colors, a palette hit and a third entry.
        push_pixel(px(1'b1, 0,   8'h00, 1'b0));
        push_pixel(px(1'b0, 255, 8'hFF, 1'b1));
        push_pixel(px(1'b0, 1,   8'h00, 1'b0));
        push_pixel(px(1'b0, 2,   8'hAA, 1'b0));
        drain_results();

        // Drop to 1 bit per pixel mid-frame. The palette already holds three
        // colors, above the new limit of two: the third color now overflows,
        // the first two are still found.
        write_depth(CODE_BPP1);
        push_pixel(px(1'b0, 0, 8'hAA, 1'b0));
        push_pixel(px(1'b0, 1, 8'hFF, 1'b0));
        push_pixel(px(1'b0, 2, 8'h00, 1'b0));
        push_pixel(px(1'b0, 3, 8'hFF, 1'b0));
        push_pixel(px(1'b0, 4, 8'h55, 1'b0));
        // Row ends with a partly filled byte, which goes out as it stands.
        push_pixel(px(1'b0, 5, 8'h00, 1'b1));
        // New frame: two colors fill the palette, the third overflows.
        push_pixel(px(1'b1, 0, 8'h10, 1'b0));
        push_pixel(px(1'b0, 1, 8'h20, 1'b0));
        push_pixel(px(1'b0, 2, 8'h30, 1'b0));
        // Skipped columns: slot six still merges, then column eight opens a
        // fresh byte and the leftover bits of the unfinished one are dropped.
        push_pixel(px(1'b0, 6,  8'h20, 1'b0));
        push_pixel(px(1'b0, 8,  8'h20, 1'b0));
        push_pixel(px(1'b0, 15, 8'h10, 1'b1));
        drain_results();

        // 2 bits per pixel: four colors fill a byte and the palette, a fifth
        // overflows and is flushed alone at row end.
        write_depth(CODE_BPP2);
        push_pixel(px(1'b1, 0, 8'h01, 1'b0));
        push_pixel(px(1'b0, 1, 8'h02, 1'b0));
        push_pixel(px(1'b0, 2, 8'h03, 1'b0));
        push_pixel(px(1'b0, 3, 8'h04, 1'b0));
        push_pixel(px(1'b0, 4, 8'h05, 1'b1));
        drain_results();

        // 4 bits per pixel: a byte that fills exactly at row end, then a lone
        // pixel in the high nibble flushed by row end.
        write_depth(CODE_BPP4);
        push_pixel(px(1'b1, 0, 8'h80, 1'b0));
        push_pixel(px(1'b0, 1, 8'h7F, 1'b1));
        push_pixel(px(1'b0, 2, 8'hFF, 1'b1));
        drain_results();

        // Random phases. The frame generator keeps its state across phases, so
        // depth changes often land in the middle of a frame.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 3) begin
                tx_idle_pct = 11;
                rx_idle_pct = 52;
            end else if (ph < 6) begin
                tx_idle_pct = 52;
                rx_idle_pct = 11;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            code = (ph == RANDOM_PHASES - 1) ? t_code'($urandom_range(0, 3)) : phase_codes[ph];
            write_depth(code);
            phase_num = ph;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                p = next_pixel();
                push_pixel(p);
            end
            drain_results();
        end

        // Full palette sweep at 8 bits per pixel: all 256 colors in shuffled
        // order fill every entry, then a short row of colors that must all hit.
        write_depth(CODE_BPP8);
        for (n = 0; n < 256; n++) begin
            sweep_colors[n] = n;
        end
        for (n = 255; n > 0; n--) begin
            j               = $urandom_range(0, n);
            tmp             = sweep_colors[n];
            sweep_colors[n] = sweep_colors[j];
            sweep_colors[j] = tmp;
        end
        for (n = 0; n < 256; n++) begin
            push_pixel(px(n == 0, n, sweep_colors[n], n == 255));
        end
        for (n = 0; n < 10; n++) begin
            push_pixel(px(1'b0, n, $urandom_range(0, 255), n == 9));
        end
        drain_results();

        // Let any stray result show up before the verdict.
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (chk_pending != 0) begin
            $display("ERROR: %0d results never arrived", chk_pending);
        end
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
